[rtl/fskab_pkg.sv]
`default_nettype none

package fskab_pkg;

  // Build-time configuration
  localparam int QUEUE_DEPTH        = 1024;
  localparam int SAMPLES_PER_SYMBOL = 40;
  localparam int START_SLOTS        = 1;
  localparam int MARK_FREQ_HZ       = 1200;
  localparam int SPACE_FREQ_HZ      = 2200;
  localparam int SAMPLE_RATE_HZ     = 44100;
  localparam int DATA_BITS          = 8;

  localparam int SLOT_CNT = START_SLOTS + DATA_BITS;
  localparam int QA_W     = $clog2(QUEUE_DEPTH);
  localparam int PHASE_W  = (SAMPLES_PER_SYMBOL > 1) ? $clog2(SAMPLES_PER_SYMBOL) : 1;
  localparam int SLOT_W   = $clog2(SLOT_CNT);
  localparam int BIT_W    = $clog2(DATA_BITS);

  // Operation codes on the input channel
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] PEAK_LEVEL  = 64'd32766;

  typedef logic signed [15:0] sample_t;
  typedef sample_t rom_t [SAMPLES_PER_SYMBOL];

  // Stage-1 to stage-2 control beat
  typedef struct packed {
    logic               play;
    logic [BIT_W-1:0]   bit_k;
    logic [PHASE_W-1:0] phase;
    logic               busy;
    logic               ovf;
  } beat_t;

  // Sine of a Q32 turn fraction, signed Q30; Taylor series in Horner form.
  function automatic longint sine_turn(logic [31:0] turn);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    quad = turn[31:30];
    r    = {34'd0, turn[29:0]};
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  // One enveloped tone sample; elaboration only.
  function automatic sample_t rom_value(int idx, int freq);
    logic [63:0] env_turn;
    logic [63:0] env;
    logic [63:0] a;
    logic [63:0] tone_turn;
    logic [63:0] mag;
    logic [63:0] v;
    longint      c;
    longint      s;
    env_turn  = (64'(idx) << 32) / SAMPLES_PER_SYMBOL;
    c         = sine_turn(env_turn[31:0] + 32'h4000_0000);
    env       = 64'((longint'(Q30_ONE) - c) / 3);
    a         = (64'(freq) * 64'(idx)) % SAMPLE_RATE_HZ;
    tone_turn = (a << 32) / SAMPLE_RATE_HZ;
    s         = sine_turn(tone_turn[31:0]);
    mag       = (s < 0) ? 64'(-s) : 64'(s);
    v         = (((env * mag) >> 30) * PEAK_LEVEL) >> 30;
    return (s < 0) ? -sample_t'(v[15:0]) : sample_t'(v[15:0]);
  endfunction

  function automatic rom_t build_rom(int freq);
    rom_t rom;
    for (int i = 0; i < SAMPLES_PER_SYMBOL; i++) begin
      rom[i] = rom_value(i, freq);
    end
    return rom;
  endfunction

  localparam rom_t MARK_ROM  = build_rom(MARK_FREQ_HZ);
  localparam rom_t SPACE_ROM = build_rom(SPACE_FREQ_HZ);

endpackage

`default_nettype wire

[rtl/fskab_if.sv]
`default_nettype none

interface fskab_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface fskab_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               busy_res;
  logic               overflow;

  modport source (output valid, output sample, output busy_res, output overflow,
                  input ready);
  modport sink   (input valid, input sample, input busy_res, input overflow,
                  output ready);
endinterface

`default_nettype wire

[rtl/fskab_ram.sv]
`default_nettype none

module fskab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/fskab_ctrl.sv]
`default_nettype none

module fskab_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_operation,
  input  wire logic [7:0]                in_data_byte,
  output logic                           in_ready,
  input  wire logic                      adv,
  output logic                           ram_we,
  output logic      [fskab_pkg::QA_W-1:0] ram_waddr,
  output logic      [7:0]                ram_wdata,
  output logic                           ram_re,
  output logic      [fskab_pkg::QA_W-1:0] ram_raddr,
  output logic                           s1_valid,
  output fskab_pkg::beat_t               s1_beat
);

  import fskab_pkg::*;

  logic [QA_W-1:0]    rd_r, rd_nxt, rd_inc;
  logic [QA_W-1:0]    wr_r, wr_nxt, wr_inc;
  logic [SLOT_W-1:0]  slot_r, slot_nxt, slot_inc;
  logic [PHASE_W-1:0] ph_r, ph_nxt, ph_inc;
  logic               s1_valid_r, s1_valid_nxt;
  beat_t              beat_r, beat_nxt;
  logic               accept, busy, full;
  logic [SLOT_W-1:0]  slot_ofs;

  always_comb begin
    in_ready = !s1_valid_r || adv;
    accept   = in_valid && in_ready;
    busy     = rd_r != wr_r;

    rd_inc   = (rd_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    wr_inc   = (wr_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    ph_inc   = (ph_r == PHASE_W'(SAMPLES_PER_SYMBOL - 1)) ? '0 : ph_r + 1'b1;
    slot_inc = (slot_r == SLOT_W'(SLOT_CNT - 1)) ? '0 : slot_r + 1'b1;
    full     = wr_inc == rd_r;

    rd_nxt   = rd_r;
    wr_nxt   = wr_r;
    ph_nxt   = ph_r;
    slot_nxt = slot_r;
    ram_we   = 1'b0;

    if (accept) begin
      if (in_operation == OP_ENQUEUE) begin
        if (!full) begin
          ram_we = 1'b1;
          wr_nxt = wr_inc;
        end
      end else if (busy) begin
        ph_nxt = ph_inc;
        if (ph_inc == '0) begin
          slot_nxt = slot_inc;
          if (slot_inc == '0) begin
            rd_nxt = rd_inc;
          end
        end
      end
    end

    // silent on enqueue beats, in start slots and once the last byte has gone out
    slot_ofs       = slot_nxt - SLOT_W'(START_SLOTS);
    beat_nxt.play  = (in_operation == OP_TICK) && busy && (rd_nxt != wr_r) &&
                     (slot_nxt >= SLOT_W'(START_SLOTS));
    beat_nxt.bit_k = slot_ofs[BIT_W-1:0];
    beat_nxt.phase = ph_nxt;
    beat_nxt.busy  = busy;
    beat_nxt.ovf   = (in_operation == OP_ENQUEUE) && full;

    s1_valid_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

    ram_waddr = wr_r;
    ram_wdata = in_data_byte;
    ram_re    = accept;
    ram_raddr = rd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r       <= '0;
      wr_r       <= '0;
      ph_r       <= '0;
      slot_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      rd_r       <= rd_nxt;
      wr_r       <= wr_nxt;
      ph_r       <= ph_nxt;
      slot_r     <= slot_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= beat_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = beat_r;

endmodule

`default_nettype wire

[rtl/fskab_shaper.sv]
`default_nettype none

module fskab_shaper (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire fskab_pkg::beat_t  s1_beat,
  input  wire logic [7:0]        byte_data,
  output logic                   adv,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output fskab_pkg::sample_t     out_sample,
  output logic                   out_busy_res,
  output logic                   out_overflow
);

  import fskab_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  sample_t sample_r, sample_nxt;
  logic    busy_r, ovf_r;

  always_comb begin
    adv           = !out_valid_r || out_ready;
    out_valid_nxt = adv ? s1_valid : out_valid_r;
    if (!s1_beat.play) begin
      sample_nxt = '0;
    end else if (byte_data[s1_beat.bit_k]) begin
      sample_nxt = MARK_ROM[s1_beat.phase];
    end else begin
      sample_nxt = SPACE_ROM[s1_beat.phase];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      sample_r <= sample_nxt;
      busy_r   <= s1_beat.busy;
      ovf_r    <= s1_beat.ovf;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = sample_r;
  assign out_busy_res = busy_r;
  assign out_overflow = ovf_r;

endmodule

`default_nettype wire

[rtl/fsk_audio_byte_transmitter_top.sv]
// Channel   Dir  Beat fields                       Meaning
// in_if     in   operation[0], data_byte[7:0]      0: enqueue byte, 1: sample tick
// out_if    out  sample[15:0] s, busy_res, overflow one result per input beat
//
// Throughput: one input beat per clock while out_ready does not hold the output.
// Pipeline: stage 1 registers each accepted beat; it updates the queue pointers
//   and phase/slot counters and launches the byte memory read. Stage 2 then
//   picks the bit and looks up the mark/space tone table into the output register.
// Reset: synchronous, active low; clears pointers, counters and valid flags.
//   The byte memory is not cleared, only written entries are ever played.
// Stalls: out_ready low holds the result; input is still taken while stage 1 is free.
`default_nettype none

module fsk_audio_byte_transmitter_top (
  input wire logic   clk,
  input wire logic   rst_n,
  fskab_in_if.sink   in_if,
  fskab_out_if.source out_if
);

  import fskab_pkg::*;

  logic            adv;
  logic            ram_we, ram_re;
  logic [QA_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  logic            s1_valid;
  beat_t           s1_beat;
  logic            in_ready;
  logic            out_valid, out_busy_res, out_overflow;
  sample_t         out_sample;

  // Stage 1: queue pointers, symbol counters, memory read launch
  fskab_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_operation (in_if.operation),
    .in_data_byte (in_if.data_byte),
    .in_ready     (in_ready),
    .adv          (adv),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .s1_valid     (s1_valid),
    .s1_beat      (s1_beat)
  );

  // Circular byte queue storage
  fskab_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage 2: bit select, tone lookup, output register
  fskab_shaper u_shaper (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1_beat      (s1_beat),
    .byte_data    (ram_rdata),
    .adv          (adv),
    .out_ready    (out_if.ready),
    .out_valid    (out_valid),
    .out_sample   (out_sample),
    .out_busy_res (out_busy_res),
    .out_overflow (out_overflow)
  );

  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid;
  assign out_if.sample   = out_sample;
  assign out_if.busy_res = out_busy_res;
  assign out_if.overflow = out_overflow;

endmodule

`default_nettype wire

[rtl/fskab_checker.sv]
`default_nettype none

module fskab_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] sample,
  input wire logic        busy_res,
  input wire logic        overflow
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample) &&
      $stable(busy_res) && $stable(overflow))
    else $error("result changed while stalled");

  // a full queue is never empty, and an enqueue carries no audio
  a_ovf_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> busy_res && sample == 16'd0)
    else $error("overflow without busy queue");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> sample == 16'd0 && !overflow)
    else $error("sound from an empty queue");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register always frees the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind fsk_audio_byte_transmitter_top fskab_checker u_fskab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .sample    (out_if.sample),
  .busy_res  (out_if.busy_res),
  .overflow  (out_if.overflow)
);

`default_nettype wire
